### src/xed_pkg.sv
// Shared types, constants and helper functions for the XML entity decoder.
// Depends on nothing; every other file of the decoder refers to it by scoped names.
`timescale 1ns / 1ps
package xed_pkg;

   // Longest entity body that is held before the token is flushed verbatim.
   localparam int MaxEntityLen = 16;
   localparam int CntW = $clog2(MaxEntityLen + 1);
   localparam int IdxW = $clog2(MaxEntityLen);
   // One run holds at most '&', the held bytes and one trailing byte.
   localparam int LenW = $clog2(MaxEntityLen + 3);

   localparam logic [20:0] CodeMax = 21'h10FFFF;
   localparam logic [20:0] CodeSat = 21'h110000;

   localparam logic [7:0] ChAmp   = 8'h26;
   localparam logic [7:0] ChSemi  = 8'h3B;
   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChLowX  = 8'h78;
   localparam logic [7:0] ChUpX   = 8'h58;
   localparam logic [7:0] ChLt    = 8'h3C;
   localparam logic [7:0] ChGt    = 8'h3E;
   localparam logic [7:0] ChQuot  = 8'h22;
   localparam logic [7:0] ChApos  = 8'h27;

   localparam int NumNames = 5;

   // Description of the bytes that one accepted beat produces.
   typedef struct packed {
      logic            has_out;   // the beat produces at least one byte
      logic            is_flush;  // '&', held bytes, optional tail byte
      logic [31:0]     lit;       // literal bytes, first one in the low bits
      logic [7:0]      tail;      // byte after the held bytes of a flush
      logic [CntW-1:0] cnt;       // held bytes in a flush
      logic [LenW-1:0] len;       // total bytes of the run
      logic            eot;       // the run ends the text
   } job_type;

   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  n;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   // Character k of entity name i (amp, lt, gt, quot, apos); zero past its end.
   function automatic logic [7:0] name_char(input logic [2:0] i, input logic [1:0] k);
      logic [7:0] c;
      c = 8'h00;
      case (i)
         3'd0: begin
            case (k)
               2'd0: c = 8'h61;
               2'd1: c = 8'h6D;
               2'd2: c = 8'h70;
               default: c = 8'h00;
            endcase
         end
         3'd1: begin
            case (k)
               2'd0: c = 8'h6C;
               2'd1: c = 8'h74;
               default: c = 8'h00;
            endcase
         end
         3'd2: begin
            case (k)
               2'd0: c = 8'h67;
               2'd1: c = 8'h74;
               default: c = 8'h00;
            endcase
         end
         3'd3: begin
            case (k)
               2'd0: c = 8'h71;
               2'd1: c = 8'h75;
               2'd2: c = 8'h6F;
               default: c = 8'h74;
            endcase
         end
         3'd4: begin
            case (k)
               2'd0: c = 8'h61;
               2'd1: c = 8'h70;
               2'd2: c = 8'h6F;
               default: c = 8'h73;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] name_len(input logic [2:0] i);
      logic [2:0] n;
      case (i)
         3'd0: n = 3'd3;
         3'd1: n = 3'd2;
         3'd2: n = 3'd2;
         3'd3: n = 3'd4;
         3'd4: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] name_out(input logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0: c = ChAmp;
         3'd1: c = ChLt;
         3'd2: c = ChGt;
         3'd3: c = ChQuot;
         3'd4: c = ChApos;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic digit_type digit_of(input logic [7:0] b, input logic hex);
      digit_type d;
      d.ok = 1'b0;
      d.value = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         d.ok = 1'b1;
         d.value = 4'(b - 8'h30);
      end else if (hex && (b inside {[8'h61:8'h66]})) begin
         d.ok = 1'b1;
         d.value = 4'(b - 8'h57);
      end else if (hex && (b inside {[8'h41:8'h46]})) begin
         d.ok = 1'b1;
         d.value = 4'(b - 8'h37);
      end
      return d;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] c);
      utf8_type u;
      u.bytes = 32'h0;
      if (c <= 21'h7F) begin
         u.n = 3'd1;
         u.bytes[7:0] = c[7:0];
      end else if (c <= 21'h7FF) begin
         u.n = 3'd2;
         u.bytes[7:0]  = 8'hC0 | {3'b000, c[10:6]};
         u.bytes[15:8] = 8'h80 | {2'b00, c[5:0]};
      end else if (c <= 21'hFFFF) begin
         u.n = 3'd3;
         u.bytes[7:0]   = 8'hE0 | {4'h0, c[15:12]};
         u.bytes[15:8]  = 8'h80 | {2'b00, c[11:6]};
         u.bytes[23:16] = 8'h80 | {2'b00, c[5:0]};
      end else begin
         u.n = 3'd4;
         u.bytes[7:0]   = 8'hF0 | {5'h00, c[20:18]};
         u.bytes[15:8]  = 8'h80 | {2'b00, c[17:12]};
         u.bytes[23:16] = 8'h80 | {2'b00, c[11:6]};
         u.bytes[31:24] = 8'h80 | {2'b00, c[5:0]};
      end
      return u;
   endfunction

endpackage

### src/xed_parse.sv
// Entity tracker: holds the collection state and the held entity bytes, and turns
// each accepted beat into a run description for the emitter. Uses xed_pkg.
`timescale 1ns / 1ps
module xed_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                in_byte,
   input  logic                      end_of_text,
   input  logic [xed_pkg::IdxW-1:0]  rd_idx,
   output logic [7:0]                rd_data,
   output xed_pkg::job_type          job_in
);

   logic                              inside_ff, inside_in;
   logic [xed_pkg::CntW-1:0]          count_ff, count_in;
   logic [20:0]                       code_ff, code_in;
   logic                              valid_ff, valid_in;
   logic [xed_pkg::NumNames-1:0]      flags_ff, flags_in;
   logic                              hex_ff, hex_in;
   logic [7:0]                        entity_chars_ff [xed_pkg::MaxEntityLen];
   logic                              wr_en;

   logic                              is_hex;
   xed_pkg::digit_type                dig;
   logic [24:0]                       next_val;
   xed_pkg::utf8_type                 utf;
   logic                              name_hit;
   logic [7:0]                        name_byte;
   logic                              held_full;

   assign held_full = (count_ff >= xed_pkg::CntW'(xed_pkg::MaxEntityLen));
   assign is_hex = (count_ff >= xed_pkg::CntW'(2)) && hex_ff;
   assign dig = xed_pkg::digit_of(in_byte, is_hex);
   assign utf = xed_pkg::utf8_encode(code_ff);
   assign rd_data = entity_chars_ff[rd_idx];

   // Multiply by 16 or by 10 with shifts; the value is at most 21 bits here.
   always_comb begin
      if (is_hex) begin
         next_val = {code_ff, 4'h0} + 25'(dig.value);
      end else begin
         next_val = {1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + 25'(dig.value);
      end
   end

   // The lowest-numbered name that is fully matched wins.
   always_comb begin
      name_hit = 1'b0;
      name_byte = 8'h00;
      for (int i = xed_pkg::NumNames - 1; i >= 0; i--) begin
         if (flags_ff[i] && (count_ff == xed_pkg::CntW'(xed_pkg::name_len(3'(i))))) begin
            name_hit = 1'b1;
            name_byte = xed_pkg::name_out(3'(i));
         end
      end
   end

   assign wr_en = accept && inside_ff && (in_byte != xed_pkg::ChSemi) && !held_full;

   always_comb begin
      inside_in = inside_ff;
      count_in  = count_ff;
      code_in   = code_ff;
      valid_in  = valid_ff;
      flags_in  = flags_ff;
      hex_in    = hex_ff;
      job_in    = '0;
      job_in.eot = end_of_text;

      if (accept) begin
         if (!inside_ff) begin
            if ((in_byte == xed_pkg::ChAmp) && !end_of_text) begin
               inside_in = 1'b1;
               count_in  = '0;
               code_in   = '0;
               valid_in  = 1'b1;
               flags_in  = '1;
               hex_in    = 1'b0;
            end else begin
               job_in.has_out = 1'b1;
               job_in.lit     = {24'h0, in_byte};
               job_in.len     = xed_pkg::LenW'(1);
            end
         end else if (in_byte == xed_pkg::ChSemi) begin
            job_in.has_out = 1'b1;
            inside_in = 1'b0;
            if (name_hit) begin
               job_in.lit = {24'h0, name_byte};
               job_in.len = xed_pkg::LenW'(1);
            end else if ((count_ff != '0) && valid_ff && (code_ff <= xed_pkg::CodeMax)) begin
               job_in.lit = utf.bytes;
               job_in.len = xed_pkg::LenW'(utf.n);
            end else begin
               job_in.is_flush = 1'b1;
               job_in.cnt  = count_ff;
               job_in.tail = xed_pkg::ChSemi;
               job_in.len  = xed_pkg::LenW'(count_ff) + xed_pkg::LenW'(2);
            end
         end else if (held_full) begin
            // Overlong token: flush it together with the byte that overflowed it.
            job_in.has_out  = 1'b1;
            job_in.is_flush = 1'b1;
            job_in.cnt  = count_ff;
            job_in.tail = in_byte;
            job_in.len  = xed_pkg::LenW'(count_ff) + xed_pkg::LenW'(2);
            inside_in = 1'b0;
         end else begin
            for (int i = 0; i < xed_pkg::NumNames; i++) begin
               if ((count_ff >= xed_pkg::CntW'(xed_pkg::name_len(3'(i))))
                   || (xed_pkg::name_char(3'(i), count_ff[1:0]) != in_byte)) begin
                  flags_in[i] = 1'b0;
               end
            end
            if (count_ff == '0) begin
               valid_in = (in_byte == xed_pkg::ChHash);
            end else if (valid_ff && !((count_ff == xed_pkg::CntW'(1))
                         && ((in_byte == xed_pkg::ChLowX) || (in_byte == xed_pkg::ChUpX)))) begin
               if (!dig.ok) begin
                  valid_in = 1'b0;
               end else if (code_ff > xed_pkg::CodeMax) begin
                  code_in = xed_pkg::CodeSat;
               end else if (next_val > 25'(xed_pkg::CodeMax)) begin
                  code_in = xed_pkg::CodeSat;
               end else begin
                  code_in = next_val[20:0];
               end
            end
            if (count_ff == xed_pkg::CntW'(1)) begin
               hex_in = (in_byte == xed_pkg::ChLowX) || (in_byte == xed_pkg::ChUpX);
            end
            count_in = count_ff + xed_pkg::CntW'(1);
            if (end_of_text) begin
               job_in.has_out  = 1'b1;
               job_in.is_flush = 1'b1;
               job_in.cnt  = count_ff + xed_pkg::CntW'(1);
               job_in.len  = xed_pkg::LenW'(count_ff) + xed_pkg::LenW'(2);
            end
         end

         if (end_of_text || !inside_in) begin
            inside_in = 1'b0;
            count_in  = '0;
            code_in   = '0;
            valid_in  = 1'b1;
            flags_in  = '1;
            hex_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
         code_ff   <= '0;
         valid_ff  <= 1'b1;
         flags_ff  <= '1;
         hex_ff    <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         count_ff  <= count_in;
         code_ff   <= code_in;
         valid_ff  <= valid_in;
         flags_ff  <= flags_in;
         hex_ff    <= hex_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entity_chars_ff[count_ff[xed_pkg::IdxW-1:0]] <= in_byte;
      end
   end

endmodule

### src/xed_emit.sv
// Run emitter: holds the pending run and a byte position, and feeds the result
// register one byte per cycle unless out_ready stalls. Uses xed_pkg; reads held bytes from xed_parse.
`timescale 1ns / 1ps
module xed_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  xed_pkg::job_type          job_in,
   output logic                      take_ready,
   output logic [xed_pkg::IdxW-1:0]  rd_idx,
   input  logic [7:0]                rd_data,
   output logic                      out_valid,
   output logic [7:0]                out_byte,
   output logic                      out_last,
   output logic                      out_end,
   input  logic                      out_ready
);

   xed_pkg::job_type          job_ff;
   logic                      job_valid_ff;
   logic [xed_pkg::LenW-1:0]  pos_ff;
   logic                      rsp_valid_ff;
   logic [7:0]                rsp_byte_ff;
   logic                      rsp_last_ff;
   logic                      rsp_end_ff;

   logic                      load;
   logic                      at_end;
   logic                      job_done;
   logic [7:0]                cur_byte;

   assign load = !rsp_valid_ff || out_ready;
   assign at_end = (pos_ff == (job_ff.len - xed_pkg::LenW'(1)));
   assign job_done = job_valid_ff && load && at_end;
   // A new beat may enter as the last byte of the current run leaves.
   assign take_ready = !job_valid_ff || job_done;

   assign rd_idx = xed_pkg::IdxW'(pos_ff - xed_pkg::LenW'(1));

   always_comb begin
      if (job_ff.is_flush) begin
         if (pos_ff == '0) begin
            cur_byte = xed_pkg::ChAmp;
         end else if (pos_ff <= xed_pkg::LenW'(job_ff.cnt)) begin
            cur_byte = rd_data;
         end else begin
            cur_byte = job_ff.tail;
         end
      end else begin
         cur_byte = job_ff.lit[pos_ff[1:0]*8 +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && job_in.has_out) begin
            job_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (job_done) begin
            job_valid_ff <= 1'b0;
         end else if (job_valid_ff && load) begin
            pos_ff <= pos_ff + xed_pkg::LenW'(1);
         end
         if (load) begin
            rsp_valid_ff <= job_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && job_in.has_out) begin
         job_ff <= job_in;
      end
      if (load && job_valid_ff) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= at_end;
         rsp_end_ff  <= at_end && job_ff.eot;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_byte  = rsp_byte_ff;
   assign out_last  = rsp_last_ff;
   assign out_end   = rsp_end_ff;

endmodule

### src/xml_entity_decoder_utf8.sv
// Top level of the XML entity decoder with UTF-8 output.
// Instantiates xed_parse and xed_emit; uses xed_pkg.
`timescale 1ns / 1ps
// Usage:
// The req_ channel carries escaped text one byte per beat; req_tlast marks the
// final byte of a text. The rsp_ channel carries the unescaped UTF-8 bytes;
// rsp_tlast is high on the last byte that one input beat produces and rsp_tuser
// on the very last byte of a text. A '&' and the bytes of an open entity
// produce nothing until the entity closes, overflows or the text ends.
// The first byte of a beat's run is presented on rsp_ after it passes the run
// register, then the result register.
// Throughput: a beat that yields zero or one byte does not itself hold req_tready
// low; a beat that yields n bytes (a UTF-8 sequence of up to 4, or a verbatim flush
// of up to 18 bytes) holds req_tready low until its last byte is loaded, one result
// register load per cycle while rsp_tready allows it being the limit.
// When rsp_tready is low the result register holds its byte and the run stops
// in place; req_tready then stays low once a run is pending.
// Reset (synchronous, active high) drops any open entity and pending output.
module xml_entity_decoder_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] text_end
);

   logic                      accept;
   logic                      take_ready;
   xed_pkg::job_type          job_in;
   logic [xed_pkg::IdxW-1:0]  rd_idx;
   logic [7:0]                rd_data;

   assign req_tready = take_ready;
   assign accept = req_tvalid && take_ready;

   xed_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .end_of_text (req_tlast),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data),
      .job_in      (job_in)
   );

   xed_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .job_in     (job_in),
      .take_ready (take_ready),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data),
      .out_valid  (rsp_tvalid),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast),
      .out_end    (rsp_tuser),
      .out_ready  (rsp_tready)
   );

endmodule

### sim/xml_entity_decoder_utf8_tb.sv
// Self-checking testbench for xml_entity_decoder_utf8: a scoreboard class predicts the
// decoded UTF-8 bytes of every accepted text beat and checks each result beat in order.
// Depends on xed_pkg and the decoder RTL only.
`timescale 1ns / 1ps
module xml_entity_decoder_utf8_tb;

   localparam int CycleLimit = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       text_end;
   } decoded_beat_type;

   class utf8_decode_board_type;
      string            entity_name [5] = '{"amp", "lt", "gt", "quot", "apos"};
      logic [7:0]       entity_char [5];
      logic             in_entity;
      logic [7:0]       held [xed_pkg::MaxEntityLen];
      int               held_cnt;
      logic [20:0]      code;
      logic             code_ok;
      logic [4:0]       name_ok;
      decoded_beat_type decoded_q[$];
      decoded_beat_type run[$];
      int               errors;
      int               checked;
      int               beats_in;
      int               texts;
      int               named_cnt;
      int               verbatim_cnt;
      int               utf8_cnt [1:4];

      function new();
         entity_char = '{xed_pkg::ChAmp, xed_pkg::ChLt, xed_pkg::ChGt, xed_pkg::ChQuot,
                         xed_pkg::ChApos};
         restart(1'b0);
      endfunction

      function void restart(input logic enter);
         in_entity = enter;
         held_cnt  = 0;
         code      = '0;
         code_ok   = 1'b1;
         name_ok   = 5'h1F;
      endfunction

      function void emit(input logic [7:0] b);
         decoded_beat_type r;
         r.data     = b;
         r.run_last = 1'b0;
         r.text_end = 1'b0;
         run = {run, r};
      endfunction

      function void flush_entity();
         emit(xed_pkg::ChAmp);
         for (int k = 0; k < held_cnt; k++) emit(held[k]);
         verbatim_cnt++;
      endfunction

      function int digit_value(input logic [7:0] b, input logic hex);
         if (b >= "0" && b <= "9") return b - "0";
         if (hex && b >= "a" && b <= "f") return b - "a" + 10;
         if (hex && b >= "A" && b <= "F") return b - "A" + 10;
         return -1;
      endfunction

      function void hold_byte(input logic [7:0] b);
         int          k;
         int          d;
         logic        hex;
         logic [31:0] nv;
         k = held_cnt;
         for (int i = 0; i < 5; i++) begin
            if (k >= entity_name[i].len() || entity_name[i][k] != b) name_ok[i] = 1'b0;
         end
         if (k == 0) begin
            code_ok = (b == xed_pkg::ChHash);
         end else if (code_ok && !(k == 1 && (b == xed_pkg::ChLowX || b == xed_pkg::ChUpX)))
         begin
            hex = (k >= 2) && (held[1] == xed_pkg::ChLowX || held[1] == xed_pkg::ChUpX);
            d = digit_value(b, hex);
            if (d < 0) begin
               code_ok = 1'b0;
            end else if (code > xed_pkg::CodeMax) begin
               code = xed_pkg::CodeSat;
            end else begin
               nv = code * (hex ? 16 : 10) + d;
               code = (nv > xed_pkg::CodeMax) ? xed_pkg::CodeSat : nv[20:0];
            end
         end
         held[k] = b;
         held_cnt = k + 1;
      endfunction

      function void put_utf8(input logic [20:0] c);
         if (c <= 21'h7F) begin
            emit(c[7:0]);
            utf8_cnt[1]++;
         end else if (c <= 21'h7FF) begin
            emit({3'b110, c[10:6]});
            emit({2'b10, c[5:0]});
            utf8_cnt[2]++;
         end else if (c <= 21'hFFFF) begin
            emit({4'b1110, c[15:12]});
            emit({2'b10, c[11:6]});
            emit({2'b10, c[5:0]});
            utf8_cnt[3]++;
         end else begin
            emit({5'b11110, c[20:18]});
            emit({2'b10, c[17:12]});
            emit({2'b10, c[11:6]});
            emit({2'b10, c[5:0]});
            utf8_cnt[4]++;
         end
      endfunction

      function void close_entity();
         for (int i = 0; i < 5; i++) begin
            if (name_ok[i] && held_cnt == entity_name[i].len()) begin
               emit(entity_char[i]);
               named_cnt++;
               return;
            end
         end
         if (held_cnt >= 1 && held[0] == xed_pkg::ChHash && code_ok
             && code <= xed_pkg::CodeMax) begin
            put_utf8(code);
            return;
         end
         flush_entity();
         emit(xed_pkg::ChSemi);
      endfunction

      // Works out the bytes that one accepted text beat produces.
      function void note_input(input logic [7:0] b, input logic eot);
         beats_in++;
         run.delete();
         if (!in_entity) begin
            if (b == xed_pkg::ChAmp && !eot) begin
               restart(1'b1);
               return;
            end
            emit(b);
         end else if (b == xed_pkg::ChSemi) begin
            close_entity();
            restart(1'b0);
         end else if (held_cnt >= xed_pkg::MaxEntityLen) begin
            // The overflowing byte goes out verbatim, even when it is an ampersand.
            flush_entity();
            emit(b);
            restart(1'b0);
         end else begin
            hold_byte(b);
            if (!eot) return;
            flush_entity();
            restart(1'b0);
         end
         if (eot) begin
            restart(1'b0);
            texts++;
         end
         run[run.size() - 1].run_last = 1'b1;
         run[run.size() - 1].text_end = eot;
         foreach (run[i]) decoded_q = {decoded_q, run[i]};
      endfunction

      function void check_result(input logic [7:0] data, input logic last, input logic tend);
         decoded_beat_type want;
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result beat data %h last %b end %b",
                     $time, data, last, tend);
            errors++;
            return;
         end
         want = decoded_q.pop_front();
         checked++;
         if (want.data !== data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
            errors++;
         end
         if (want.run_last !== last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last, last);
            errors++;
         end
         if (want.text_end !== tend) begin
            $display("%0t: text_end expected %b actual %b", $time, want.text_end, tend);
            errors++;
         end
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   utf8_decode_board_type board;
   bit                    gaps_on = 1'b1;
   int                    cycle_count = 0;
   logic [7:0]            token[$];
   text_beat_type         stim[$];

   xml_entity_decoder_utf8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= !(gaps_on && $urandom_range(99) < 17);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles with %0d bytes outstanding.",
                  cycle_count, board.pending());
         $display("xml_entity_decoder_utf8: mismatch");
         $finish;
      end
   end

   function automatic void put_str(input string s);
      foreach (s[i]) token = {token, s[i]};
   endfunction

   // Moves the scratch token into the stimulus; last_at < 0 means no end of text.
   function automatic void commit_token(input int last_at);
      text_beat_type beat;
      foreach (token[i]) begin
         beat.data = token[i];
         beat.last = (i == last_at);
         stim = {stim, beat};
      end
      token.delete();
   endfunction

   function automatic void add_text(input string s, input bit eot);
      put_str(s);
      commit_token(eot ? token.size() - 1 : -1);
   endfunction

   function automatic void make_named();
      string s;
      int    i;
      s = board.entity_name[$urandom_range(4)];
      case ($urandom_range(9))
         0: s = s.substr(0, s.len() - 2);
         1: begin
            i = $urandom_range(s.len() - 1);
            s[i] = s[i] - 8'd32;
         end
         2: s = {s, "x"};
         default: ;
      endcase
      put_str({"&", s, ";"});
   endfunction

   function automatic void make_numeric();
      logic [31:0] v;
      string       s;
      string       pre;
      bit          hex;
      case ($urandom_range(4))
         0: v = $urandom_range(32'h7F, 0);
         1: v = $urandom_range(32'h7FF, 32'h80);
         2: v = $urandom_range(32'hFFFF, 32'h800);
         3: v = $urandom_range(32'h10FFFF, 32'h10000);
         default: v = $urandom_range(32'hFFFFFFFF, 32'h110000);
      endcase
      hex = ($urandom_range(1) == 1);
      pre = "&#";
      if (hex) begin
         s = $sformatf("%0h", v);
         foreach (s[i]) begin
            if (s[i] >= "a" && $urandom_range(1)) s[i] = s[i] - 8'd32;
         end
         if ($urandom_range(1)) pre = {pre, "x"};
         else pre = {pre, "X"};
      end else begin
         s = $sformatf("%0d", v);
      end
      if ($urandom_range(3) == 0) s = {"00", s};
      if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = "g";
      put_str({pre, s, ";"});
   endfunction

   // Long bodies of random length, some of which run past the entity limit.
   function automatic void make_long();
      logic [7:0] b;
      token = {token, xed_pkg::ChAmp};
      repeat ($urandom_range(20, 12)) begin
         b = 8'($urandom_range(8'h7A, 8'h23));
         token = {token, (b == xed_pkg::ChSemi) ? xed_pkg::ChHash : b};
      end
      if ($urandom_range(1)) token = {token, xed_pkg::ChSemi};
   endfunction

   function automatic void make_noise();
      token = {token, xed_pkg::ChAmp};
      repeat ($urandom_range(5)) token = {token, 8'($urandom_range(255))};
      if ($urandom_range(1)) token = {token, xed_pkg::ChSemi};
   endfunction

   function automatic void build_directed();
      add_text("&amp;&lt;&gt;&quot;&apos;", 1'b0);
      add_text("&#;&#x;&;", 1'b0);
      add_text("&#65;&#xe9;&#x20AC;&#X1F600;&#1114111;&#x10FFFF;", 1'b0);
      add_text("&#1114112;&#x110000;&#99999999999;", 1'b0);
      add_text("&a&b;&AMP;&ampx;&#xG;&#12a;&#xFfAb;", 1'b0);
      add_text("&abcdefghijklmnopq&abcdefghijklmnop;", 1'b0);
      // Eighteen ampersands: the last overflows the entity and stays plain.
      repeat (18) token = {token, xed_pkg::ChAmp};
      put_str("lt;");
      commit_token(-1);
      add_text("&abcdefghijklmnopZ", 1'b1);
      add_text("&lt", 1'b1);
      add_text("&lt;", 1'b1);
      add_text("&", 1'b1);
      token = {token, 8'h00};
      token = {token, 8'hFF};
      token = {token, xed_pkg::ChSemi};
      commit_token(2);
   endfunction

   function automatic void build_random(input int n_beats);
      int pick;
      while (stim.size() < n_beats) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(4, 1)) token = {token, 8'($urandom_range(255))};
         end else if (pick < 50) begin
            make_named();
         end else if (pick < 80) begin
            make_numeric();
         end else if (pick < 90) begin
            make_long();
         end else begin
            make_noise();
         end
         commit_token($urandom_range(7) == 0 ? $urandom_range(token.size() - 1) : -1);
      end
      token = {token, 8'($urandom_range(255))};
      commit_token(0);
   endfunction

   task automatic send_beat(input text_beat_type beat);
      while (gaps_on && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat.data;
      req_tlast  <= beat.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_input(beat.data, beat.last);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(negedge clock);
   endtask

   task automatic send_stim(input bit with_quiet);
      int total;
      total = stim.size();
      for (int i = 0; i < total; i++) begin
         gaps_on = !(with_quiet && i >= total / 3 && i < 2 * total / 3);
         if (with_quiet && i == total / 2) wait_drained();
         send_beat(stim[i]);
      end
      wait_drained();
      gaps_on = 1'b1;
      stim.delete();
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      build_directed();
      build_random(270);
      send_stim(1'b1);
      repeat (6) @(negedge clock);
      $display("Sent %0d text beats in %0d ended texts; checked %0d decoded bytes.",
               board.beats_in, board.texts, board.checked);
      $display("Named %0d, UTF-8 of 1/2/3/4 bytes %0d/%0d/%0d/%0d, verbatim flushes %0d.",
               board.named_cnt, board.utf8_cnt[1], board.utf8_cnt[2], board.utf8_cnt[3],
               board.utf8_cnt[4], board.verbatim_cnt);
      if (board.errors == 0) begin
         $display("xml_entity_decoder_utf8: match");
      end else begin
         $display("xml_entity_decoder_utf8: mismatch");
      end
      $finish;
   end

endmodule

### xml_entity_decoder_utf8.f
src/xed_pkg.sv
src/xed_parse.sv
src/xed_emit.sv
src/xml_entity_decoder_utf8.sv
sim/xml_entity_decoder_utf8_tb.sv
